### sv/assert_macros.svh
// Concurrent assertion helpers, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### sv/qim_pkg.sv
`timescale 1ns / 1ps
package qim_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int OUT_W       = 32;
    localparam int PPI_W       = 24;
    localparam int HYST_W      = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [PPI_W-1:0]  PPI_RESET  = PPI_W'(1000);
    localparam logic [HYST_W-1:0] HYST_RESET = HYST_W'(14);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PPI  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST = 1'b1;

    // input word kinds
    localparam logic OP_PINS = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // run commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PAUSE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_UP,
        STEP_DOWN
    } t_step;

    // x4 decode from {old B, old A, new B, new A}
    function automatic t_step quad_step(input logic [3:0] code);
        t_step s;
        case (code)
            4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_UP;
            4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
            default:                  s = STEP_NONE;
        endcase
        return s;
    endfunction

    // sign-extend or truncate a count to the output width
    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        return OUT_W'($signed(v));
    endfunction

endpackage

### sv/qim_divider.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qim_divider
    import qim_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_dividend,
    input  logic [PPI_W-1:0]       i_divisor,
    output logic                   o_done,
    output logic [COUNT_WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(COUNT_WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PPI_W-1:0] r_rem;
    logic [PPI_W-1:0] r_dsr;
    logic [COUNT_WIDTH-1:0] r_dvd;

    logic [PPI_W:0]   n_shift;
    logic [PPI_W:0]   n_diff;
    logic             n_qbit;
    logic [PPI_W-1:0] n_rem;

    // one restoring step: bring down the next dividend bit, try the subtract
    always_comb begin
        n_shift = {r_rem, r_dvd[COUNT_WIDTH-1]};
        n_diff  = n_shift - {1'b0, r_dsr};
        n_qbit  = ~n_diff[PPI_W];
        n_rem   = n_qbit ? n_diff[PPI_W-1:0] : n_shift[PPI_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(COUNT_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits as they are consumed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[COUNT_WIDTH-2:0], n_qbit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `ASSERT_IMPLIES(a_start_idle, i_clk, i_rst_n, i_start, !r_busy && !r_done)

endmodule

### sv/quadrature_interval_marker.sv
`timescale 1ns / 1ps
// x4 quadrature decoder with interval boundary marks. No new word is taken until
// the current one reaches the output register: a pin-change word passes through
// the arm, divide, mark and output states, and the bit-serial divider that forms
// the interval index retires one quotient bit per clock. A run-command word goes
// straight to the output state. Exactly one result word comes out per input word; a
// finished result waits in the output register while the next word is taken.
`include "assert_macros.svh"
module quadrature_interval_marker
    import qim_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [PPI_W-1:0]        i_cfg_wdata,

    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_op,
    input  logic [1:0]              i_pins_ab,
    input  logic [1:0]              i_command,

    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_position,
    output logic signed [OUT_W-1:0] o_mark,
    output logic                    o_mark_accepted,
    output logic                    o_motor_on,
    output logic                    o_tracking
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_DIV,
        S_MARK,
        S_OUT
    } t_state;

    t_state r_state;

    logic [PPI_W-1:0]       r_ppi;
    logic [HYST_W-1:0]      r_hyst;

    logic [1:0]             r_pins;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_trig;
    logic [COUNT_WIDTH-1:0] r_last;
    logic [COUNT_WIDTH-1:0] r_mark;
    logic [COUNT_WIDTH-1:0] r_idx;
    logic                   r_rearmed;
    logic                   r_motor;
    logic                   r_run;
    logic                   r_hit;

    logic                   r_ovalid;
    logic [OUT_W-1:0]       r_opos;
    logic [OUT_W-1:0]       r_omark;
    logic                   r_ohit;
    logic                   r_omotor;
    logic                   r_orun;

    logic                   in_acc;
    logic                   out_free;
    t_step                  n_step;
    logic [COUNT_WIDTH-1:0] n_delta;
    logic [COUNT_WIDTH-1:0] n_dmag;
    logic                   n_rearm;
    logic [COUNT_WIDTH-1:0] n_dividend;
    logic [PPI_W-1:0]       n_divisor;
    logic [COUNT_WIDTH-1:0] n_idx;
    logic [COUNT_WIDTH-1:0] n_crossed;
    logic                   div_start;
    logic                   div_done;
    logic [COUNT_WIDTH-1:0] div_quot;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    always_comb begin
        n_step     = quad_step({r_pins, i_pins_ab});
        n_delta    = r_count - r_trig;
        n_dmag     = n_delta[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - n_delta) : n_delta;
        n_rearm    = n_dmag > COUNT_WIDTH'(r_hyst);
        n_dividend = r_count[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - r_count) : r_count;
        // a zero divisor acts as one
        n_divisor  = (r_ppi == '0) ? PPI_W'(1) : r_ppi;
        n_idx      = r_count[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - div_quot) : div_quot;
        // backward crossings mark the boundary above the new index
        n_crossed  = ($signed(r_idx) > $signed(r_last)) ? r_idx
                                                         : (r_idx + COUNT_WIDTH'(1));
    end

    assign div_start = (r_state == S_ARM);

    qim_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppi  <= PPI_RESET;
            r_hyst <= HYST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PPI:  r_ppi  <= i_cfg_wdata;
                CFG_HYST: r_hyst <= i_cfg_wdata[HYST_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pins    <= '0;
            r_count   <= '0;
            r_trig    <= '0;
            r_last    <= '0;
            r_mark    <= '0;
            r_idx     <= '0;
            r_rearmed <= 1'b1;
            r_motor   <= 1'b0;
            r_run     <= 1'b0;
            r_hit     <= 1'b0;
            r_ovalid  <= 1'b0;
            r_opos    <= '0;
            r_omark   <= '0;
            r_ohit    <= 1'b0;
            r_omotor  <= 1'b0;
            r_orun    <= 1'b0;
        end else begin
            // drop a taken word unless a new one is loaded this cycle
            if (r_ovalid && !i_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_hit <= 1'b0;
                        if (i_op == OP_PINS) begin
                            r_pins <= i_pins_ab;
                            unique case (n_step)
                                STEP_UP:   r_count <= r_count + COUNT_WIDTH'(1);
                                STEP_DOWN: r_count <= r_count - COUNT_WIDTH'(1);
                                default:   ;
                            endcase
                            r_state <= S_ARM;
                        end else begin
                            unique case (i_command)
                                CMD_START: begin
                                    r_motor <= 1'b1;
                                    r_run   <= 1'b1;
                                end
                                CMD_PAUSE: r_motor <= 1'b0;
                                CMD_STOP: begin
                                    r_motor <= 1'b0;
                                    r_run   <= 1'b0;
                                end
                                default: begin
                                    r_count   <= '0;
                                    r_trig    <= '0;
                                    r_last    <= '0;
                                    r_mark    <= '0;
                                    r_rearmed <= 1'b1;
                                end
                            endcase
                            r_state <= S_OUT;
                        end
                    end
                end
                S_ARM: begin
                    if (!r_rearmed && n_rearm) begin
                        r_rearmed <= 1'b1;
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_idx   <= n_idx;
                        r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    if (r_idx != r_last) begin
                        if (r_rearmed) begin
                            // a tracked run stops at the mark
                            if (r_run) begin
                                r_motor <= 1'b0;
                            end
                            r_mark    <= n_crossed;
                            r_trig    <= r_count;
                            r_rearmed <= 1'b0;
                            r_hit     <= 1'b1;
                        end
                        r_last <= r_idx;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_opos   <= to_out(r_count);
                        r_omark  <= to_out(r_mark);
                        r_ohit   <= r_hit;
                        r_omotor <= r_motor;
                        r_orun   <= r_run;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_position      = $signed(r_opos);
    assign o_mark          = $signed(r_omark);
    assign o_mark_accepted = r_ohit;
    assign o_motor_on      = r_omotor;
    assign o_tracking      = r_orun;

    `ASSERT_IMPLIES(a_motor_needs_run, i_clk, i_rst_n, r_motor, r_run)
    `ASSERT_IMPLIES(a_hit_disarms, i_clk, i_rst_n, (r_state == S_OUT) && r_hit, !r_rearmed)
    `ASSERT_IMPLIES(a_mark_stops, i_clk, i_rst_n, o_valid && o_mark_accepted, !o_motor_on)
    `ASSERT_IMPLIES(a_div_done_state, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall)

endmodule
